// ----- rtl/tagged_hw_queue_dispatcher_unit_defines.svh -----
// Assertion macros used by the dispatcher top level.
`ifndef TAGGED_HW_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`define TAGGED_HW_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge, skipping cycles in reset.
`define THDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define THDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define THDQ_ASSERT(lbl, prop, msg)
`define THDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/thdq_pkg.sv -----
// Types, constants and helper functions of the tagged queue dispatcher.
package thdq_pkg;

    localparam int TAG_COUNT  = 256;
    localparam int TAG_W      = 8;
    localparam int MAX_QUEUES = 16;
    localparam int QUEUE_W    = 4;
    localparam int OWNER_W    = 5;
    localparam int QC_W       = 5;
    localparam int CNT_W      = 32;
    localparam int ROW_W      = 4 * CNT_W;
    localparam int GRP_SIZE   = 16;
    localparam int GRP_N      = TAG_COUNT / GRP_SIZE;
    localparam int GRP_W      = 4;
    localparam int RING_DEPTH = MAX_QUEUES * TAG_COUNT;
    localparam int RING_AW    = QUEUE_W + TAG_W;
    localparam int SECTOR_W   = 64;

    localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(MAX_QUEUES);

    typedef enum logic [3:0] {
        REQ_SUBMIT   = 4'd0,
        REQ_FETCH    = 4'd1,
        REQ_COMPLETE = 4'd2,
        REQ_RELEASE  = 4'd3,
        REQ_START    = 4'd4,
        REQ_STOP     = 4'd5,
        REQ_DRAIN    = 4'd6,
        REQ_EXIT     = 4'd7,
        REQ_STATS    = 4'd8
    } t_req;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_TAG      = 3'd1,
        ST_NOT_RUNNING = 3'd2,
        ST_FULL        = 3'd3,
        ST_BAD_QUEUE   = 3'd4,
        ST_BUSY        = 3'd5,
        ST_EMPTY       = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_RUNNING = 2'd0,
        MODE_STOPPED = 2'd1,
        MODE_OFFLINE = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_MOD, S_SUB_CHK, S_SUB_ST, S_CMP_OWN, S_CMP_ST,
        S_FET_RD, S_FET_DIR, S_EXIT_ST, S_STAT_ST, S_DR_LOOP, S_DR_TAG,
        S_DR_OWN, S_DR_ST, S_DR_END, S_RESP
    } t_state;

    // Commands from the sequencer to the tag pool.
    typedef struct packed {
        logic               rd;
        logic               alloc;
        logic               clr_owner;
        logic               free;
        logic [TAG_W-1:0]   tag;
        logic [QUEUE_W-1:0] owner;
        logic               dir;
    } t_tag_cmd;

    // Status from the tag pool back to the sequencer.
    typedef struct packed {
        logic               none_free;
        logic               found_ok;
        logic [TAG_W-1:0]   found_tag;
        logic [OWNER_W-1:0] owner;
        logic               dir;
    } t_tag_stat;

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   tag_out;
        logic [QUEUE_W-1:0] queue_out;
        logic               dir_out;
        logic [TAG_W-1:0]   drained;
        logic [CNT_W-1:0]   sub;
        logic [CNT_W-1:0]   comp;
        logic [CNT_W-1:0]   err;
        logic [CNT_W-1:0]   pend;
    } t_result;

    // Index of the lowest set bit of a 16-bit group.
    function automatic logic [GRP_W-1:0] lowest_set(input logic [GRP_SIZE-1:0] v);
        logic [GRP_W-1:0] idx;
        idx = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GRP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/thdq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module thdq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/thdq_mod.sv -----
// Sector modulo queue count, four sector bits per cycle.
module thdq_mod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [thdq_pkg::SECTOR_W-1:0]   i_value,
    input  logic [thdq_pkg::QC_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [thdq_pkg::QUEUE_W-1:0]    o_rem
);

    localparam int STEPS  = thdq_pkg::SECTOR_W / 4;
    localparam int STEP_W = $clog2(STEPS);

    logic [thdq_pkg::SECTOR_W-1:0] r_val;
    logic [thdq_pkg::QC_W-1:0]     r_div;
    logic [thdq_pkg::QUEUE_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]             r_cnt;
    logic                          r_busy, r_done;

    // Fold one nibble into the remainder: four shift-and-subtract steps
    always_comb begin
        logic [thdq_pkg::QC_W-1:0] t;
        t = {1'b0, r_rem};
        for (int k = 3; k >= 0; k--) begin
            t = {t[thdq_pkg::QC_W-2:0], r_val[thdq_pkg::SECTOR_W-4+k]};
            if (t >= r_div) begin
                t = t - r_div;
            end
        end
        n_rem = t[thdq_pkg::QUEUE_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[thdq_pkg::SECTOR_W-5:0], 4'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/thdq_tag_pool.sv -----
// Tag pool: free map, lowest-free search, owner and direction memory.
module thdq_tag_pool (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  thdq_pkg::t_tag_cmd   i_cmd,
    output thdq_pkg::t_tag_stat  o_stat
);

    localparam int TOT_W = $clog2(thdq_pkg::TAG_COUNT + 1);

    logic [thdq_pkg::TAG_COUNT-1:0] r_free;
    logic [thdq_pkg::TAG_COUNT-1:0] r_own_vld;
    logic [TOT_W-1:0]               r_total;
    logic [thdq_pkg::GRP_N-1:0]     grp_any;
    logic [thdq_pkg::GRP_W-1:0]     r_grp;
    logic                           r_grp_ok;
    logic [thdq_pkg::TAG_W-1:0]     r_found_tag;
    logic                           r_found_ok;
    logic                           r_rd_vld;
    logic [thdq_pkg::QUEUE_W:0]     rdata;

    // Group summary of the free map
    always_comb begin
        for (int g = 0; g < thdq_pkg::GRP_N; g++) begin
            grp_any[g] = |r_free[g*thdq_pkg::GRP_SIZE +: thdq_pkg::GRP_SIZE];
        end
    end

    // Two-stage lowest free tag search, running every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_ok   <= 1'b0;
            r_found_ok <= 1'b0;
        end else begin
            r_grp_ok   <= |grp_any;
            r_found_ok <= r_grp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp       <= thdq_pkg::lowest_set(grp_any);
        r_found_tag <= {r_grp, thdq_pkg::lowest_set(
                           r_free[{r_grp, thdq_pkg::GRP_W'(0)} +: thdq_pkg::GRP_SIZE])};
    end

    // Free map, owner valid bits and free total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '1;
            r_own_vld <= '0;
            r_total   <= TOT_W'(thdq_pkg::TAG_COUNT);
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_vld <= r_own_vld[i_cmd.tag];
            end
            if (i_cmd.alloc) begin
                r_free[i_cmd.tag]    <= 1'b0;
                r_own_vld[i_cmd.tag] <= 1'b1;
                r_total              <= r_total - 1'b1;
            end else if (i_cmd.free) begin
                r_own_vld[i_cmd.tag] <= 1'b0;
                if (!r_free[i_cmd.tag]) begin
                    r_free[i_cmd.tag] <= 1'b1;
                    r_total           <= r_total + 1'b1;
                end
            end else if (i_cmd.clr_owner) begin
                r_own_vld[i_cmd.tag] <= 1'b0;
            end
        end
    end

    // Owner and direction per tag
    thdq_ram #(
        .DEPTH (thdq_pkg::TAG_COUNT),
        .WIDTH (thdq_pkg::QUEUE_W + 1)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (i_cmd.tag),
        .i_wdata ({i_cmd.dir, i_cmd.owner}),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.tag),
        .o_rdata (rdata)
    );

    assign o_stat.none_free = (r_total == '0);
    assign o_stat.found_ok  = r_found_ok;
    assign o_stat.found_tag = r_found_tag;
    assign o_stat.owner     = r_rd_vld ? {1'b0, rdata[thdq_pkg::QUEUE_W-1:0]}
                                       : thdq_pkg::OWNER_NONE;
    assign o_stat.dir       = rdata[thdq_pkg::QUEUE_W];

endmodule

// ----- rtl/tagged_hw_queue_dispatcher_unit.sv -----
// Top level: command sequencer, dispatch rings and per-queue statistics.
//
// Takes one command at a time and gives one result per command. A result
// register sits on the output, so the next command is accepted while a result
// still waits. A submit with a free tag runs through the sector modulo unit,
// four sector bits at a time, then the ring and statistics memory
// read-modify-write; a submit with no free tag answers straight from decode.
// A drain walks the ring one queued tag at a time, through the ring memory,
// the tag memory and the statistics memory in turn. No clearing pass is
// needed after reset.
`include "tagged_hw_queue_dispatcher_unit_defines.svh"
module tagged_hw_queue_dispatcher_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [thdq_pkg::QC_W-1:0]         i_cfg_queue_count,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [3:0]                        i_req_type,
    input  logic [thdq_pkg::SECTOR_W-1:0]     i_sector,
    input  logic                              i_direction,
    input  logic [thdq_pkg::QUEUE_W-1:0]      i_queue_sel,
    input  logic [thdq_pkg::TAG_W-1:0]        i_tag_in,
    input  logic                              i_failed,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [thdq_pkg::TAG_W-1:0]        o_tag_out,
    output logic [thdq_pkg::QUEUE_W-1:0]      o_queue_out,
    output logic                              o_direction_out,
    output logic [thdq_pkg::TAG_W-1:0]        o_drained,
    output logic [thdq_pkg::CNT_W-1:0]        o_submitted_count,
    output logic [thdq_pkg::CNT_W-1:0]        o_completed_count,
    output logic [thdq_pkg::CNT_W-1:0]        o_error_count,
    output logic [thdq_pkg::CNT_W-1:0]        o_pending_count
);

    localparam int CW = thdq_pkg::CNT_W;

    thdq_pkg::t_state  r_state, n_state;
    thdq_pkg::t_result r_res, n_res, r_out;
    logic              r_out_valid;
    logic [thdq_pkg::QC_W-1:0]     r_qc, qc;

    // Latched command
    thdq_pkg::t_req                r_op;
    logic [thdq_pkg::SECTOR_W-1:0] r_sector;
    logic                          r_dir;
    logic [thdq_pkg::QUEUE_W-1:0]  r_qs;
    logic [thdq_pkg::TAG_W-1:0]    r_tag, n_tag;
    logic                          r_failed;
    logic [thdq_pkg::QUEUE_W-1:0]  r_q, n_q;
    logic [thdq_pkg::TAG_W-1:0]    r_cnt, n_cnt;

    // Per-queue ring pointers and modes
    logic [thdq_pkg::TAG_W-1:0]    r_head [thdq_pkg::MAX_QUEUES];
    logic [thdq_pkg::TAG_W-1:0]    r_tail [thdq_pkg::MAX_QUEUES];
    thdq_pkg::t_mode               r_mode [thdq_pkg::MAX_QUEUES];
    logic [thdq_pkg::MAX_QUEUES-1:0] r_st_vld;
    logic                          r_st_rvld;

    // Sequencer controls
    logic                          in_ready, out_load, mod_start, mod_done;
    logic [thdq_pkg::QUEUE_W-1:0]  mod_rem;
    logic                          head_inc, tail_inc, mode_we;
    thdq_pkg::t_mode               mode_val;
    logic                          ring_we, ring_re;
    logic [thdq_pkg::TAG_W-1:0]    ring_rdata;
    logic                          st_we, st_re;
    logic [thdq_pkg::QUEUE_W-1:0]  st_raddr;
    logic [thdq_pkg::ROW_W-1:0]    st_rdata, st_row, st_wdata;
    logic [CW-1:0]                 st_sub, st_comp, st_err, st_pend;
    thdq_pkg::t_tag_cmd            pool_cmd;
    thdq_pkg::t_tag_stat           pool_stat;
    logic                          qs_bad, queue_op, owner_in_use;

    // Effective queue count
    always_comb begin
        if (r_qc == '0) begin
            qc = thdq_pkg::QC_W'(1);
        end else if (r_qc > thdq_pkg::QC_W'(thdq_pkg::MAX_QUEUES)) begin
            qc = thdq_pkg::QC_W'(thdq_pkg::MAX_QUEUES);
        end else begin
            qc = r_qc;
        end
    end

    assign qs_bad       = ({1'b0, r_qs} >= qc);
    assign owner_in_use = (pool_stat.owner < qc);
    assign queue_op     = (r_op == thdq_pkg::REQ_FETCH) || (r_op == thdq_pkg::REQ_START) ||
                          (r_op == thdq_pkg::REQ_STOP)  || (r_op == thdq_pkg::REQ_DRAIN) ||
                          (r_op == thdq_pkg::REQ_EXIT)  || (r_op == thdq_pkg::REQ_STATS);

    // Statistics row, unwritten rows read as zero
    assign st_row  = r_st_rvld ? st_rdata : '0;
    assign st_sub  = st_row[0*CW +: CW];
    assign st_comp = st_row[1*CW +: CW];
    assign st_err  = st_row[2*CW +: CW];
    assign st_pend = st_row[3*CW +: CW];

    // Next state and controls
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_tag     = r_tag;
        n_q       = r_q;
        n_cnt     = r_cnt;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        mod_start = 1'b0;
        head_inc  = 1'b0;
        tail_inc  = 1'b0;
        mode_we   = 1'b0;
        mode_val  = thdq_pkg::MODE_RUNNING;
        ring_we   = 1'b0;
        ring_re   = 1'b0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_raddr  = r_qs;
        st_wdata  = st_row;
        pool_cmd  = '0;
        pool_cmd.tag = r_tag;

        case (r_state)
            thdq_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = thdq_pkg::S_DECODE;
                end
            end
            thdq_pkg::S_DECODE: begin
                n_state = thdq_pkg::S_RESP;
                if (r_op == thdq_pkg::REQ_SUBMIT) begin
                    if (pool_stat.none_free) begin
                        n_res.status = thdq_pkg::ST_NO_TAG;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = thdq_pkg::S_MOD;
                    end
                end else if (r_op == thdq_pkg::REQ_COMPLETE) begin
                    pool_cmd.rd = 1'b1;
                    n_state     = thdq_pkg::S_CMP_OWN;
                end else if (r_op == thdq_pkg::REQ_RELEASE) begin
                    pool_cmd.free = 1'b1;
                end else if (!queue_op) begin
                    n_state = thdq_pkg::S_RESP;
                end else if (qs_bad) begin
                    n_res.status = thdq_pkg::ST_BAD_QUEUE;
                end else begin
                    case (r_op)
                        thdq_pkg::REQ_FETCH: begin
                            if (r_mode[r_qs] != thdq_pkg::MODE_RUNNING) begin
                                n_res.status = thdq_pkg::ST_NOT_RUNNING;
                            end else if (r_head[r_qs] == r_tail[r_qs]) begin
                                n_res.status = thdq_pkg::ST_EMPTY;
                            end else begin
                                ring_re  = 1'b1;
                                head_inc = 1'b1;
                                n_state  = thdq_pkg::S_FET_RD;
                            end
                        end
                        thdq_pkg::REQ_START: begin
                            if (r_mode[r_qs] == thdq_pkg::MODE_OFFLINE) begin
                                n_res.status = thdq_pkg::ST_NOT_RUNNING;
                            end else begin
                                mode_we = 1'b1;
                            end
                        end
                        thdq_pkg::REQ_STOP: begin
                            if (r_mode[r_qs] == thdq_pkg::MODE_RUNNING) begin
                                mode_we  = 1'b1;
                                mode_val = thdq_pkg::MODE_STOPPED;
                            end
                        end
                        thdq_pkg::REQ_DRAIN: begin
                            n_cnt   = '0;
                            n_state = thdq_pkg::S_DR_LOOP;
                        end
                        thdq_pkg::REQ_EXIT: begin
                            st_re   = 1'b1;
                            n_state = thdq_pkg::S_EXIT_ST;
                        end
                        default: begin
                            st_re   = 1'b1;
                            n_state = thdq_pkg::S_STAT_ST;
                        end
                    endcase
                end
            end
            thdq_pkg::S_MOD: begin
                if (mod_done) begin
                    n_q     = mod_rem;
                    n_state = thdq_pkg::S_SUB_CHK;
                end
            end
            thdq_pkg::S_SUB_CHK: begin
                n_res.queue_out = r_q;
                n_state         = thdq_pkg::S_RESP;
                if (r_mode[r_q] != thdq_pkg::MODE_RUNNING) begin
                    n_res.status = thdq_pkg::ST_NOT_RUNNING;
                end else if (r_tail[r_q] + 1'b1 == r_head[r_q]) begin
                    n_res.status = thdq_pkg::ST_FULL;
                end else if (!pool_stat.found_ok) begin
                    n_res.status = thdq_pkg::ST_NO_TAG;
                end else begin
                    pool_cmd.alloc = 1'b1;
                    pool_cmd.tag   = pool_stat.found_tag;
                    pool_cmd.owner = r_q;
                    pool_cmd.dir   = r_dir;
                    ring_we        = 1'b1;
                    tail_inc       = 1'b1;
                    st_re          = 1'b1;
                    st_raddr       = r_q;
                    n_res.tag_out  = pool_stat.found_tag;
                    n_state        = thdq_pkg::S_SUB_ST;
                end
            end
            thdq_pkg::S_SUB_ST: begin
                st_we    = 1'b1;
                st_wdata = {st_pend + 1'b1, st_err, st_comp, st_sub + 1'b1};
                n_state  = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_CMP_OWN: begin
                pool_cmd.clr_owner = 1'b1;
                n_state            = thdq_pkg::S_RESP;
                if (owner_in_use) begin
                    n_q      = pool_stat.owner[thdq_pkg::QUEUE_W-1:0];
                    st_re    = 1'b1;
                    st_raddr = pool_stat.owner[thdq_pkg::QUEUE_W-1:0];
                    n_state  = thdq_pkg::S_CMP_ST;
                end
            end
            thdq_pkg::S_CMP_ST: begin
                st_we    = 1'b1;
                st_wdata = {st_pend - CW'(st_pend != '0), st_err + CW'(r_failed),
                            st_comp + 1'b1, st_sub};
                n_state  = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_FET_RD: begin
                n_tag        = ring_rdata;
                pool_cmd.rd  = 1'b1;
                pool_cmd.tag = ring_rdata;
                n_state      = thdq_pkg::S_FET_DIR;
            end
            thdq_pkg::S_FET_DIR: begin
                n_res.tag_out = r_tag;
                n_res.dir_out = pool_stat.dir;
                n_state       = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_EXIT_ST: begin
                if (st_pend != '0) begin
                    n_res.status = thdq_pkg::ST_BUSY;
                end else begin
                    mode_we  = 1'b1;
                    mode_val = thdq_pkg::MODE_OFFLINE;
                end
                n_state = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_STAT_ST: begin
                n_res.sub  = st_sub;
                n_res.comp = st_comp;
                n_res.err  = st_err;
                n_res.pend = st_pend;
                n_state    = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_DR_LOOP: begin
                if (r_head[r_qs] == r_tail[r_qs]) begin
                    st_re   = 1'b1;
                    n_q     = r_qs;
                    n_state = thdq_pkg::S_DR_END;
                end else begin
                    ring_re  = 1'b1;
                    head_inc = 1'b1;
                    n_state  = thdq_pkg::S_DR_TAG;
                end
            end
            thdq_pkg::S_DR_TAG: begin
                n_tag        = ring_rdata;
                pool_cmd.rd  = 1'b1;
                pool_cmd.tag = ring_rdata;
                n_state      = thdq_pkg::S_DR_OWN;
            end
            thdq_pkg::S_DR_OWN: begin
                pool_cmd.free = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                n_state       = thdq_pkg::S_DR_LOOP;
                if (owner_in_use) begin
                    n_q      = pool_stat.owner[thdq_pkg::QUEUE_W-1:0];
                    st_re    = 1'b1;
                    st_raddr = pool_stat.owner[thdq_pkg::QUEUE_W-1:0];
                    n_state  = thdq_pkg::S_DR_ST;
                end
            end
            thdq_pkg::S_DR_ST: begin
                st_we    = 1'b1;
                st_wdata = {st_pend - CW'(st_pend != '0), st_err + 1'b1,
                            st_comp + 1'b1, st_sub};
                n_state  = thdq_pkg::S_DR_LOOP;
            end
            thdq_pkg::S_DR_END: begin
                st_we         = 1'b1;
                st_wdata      = {CW'(0), st_err, st_comp, st_sub};
                mode_we       = 1'b1;
                mode_val      = thdq_pkg::MODE_OFFLINE;
                n_res.drained = r_cnt;
                n_state       = thdq_pkg::S_RESP;
            end
            thdq_pkg::S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = thdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = thdq_pkg::S_IDLE;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= thdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_qc        <= thdq_pkg::QC_W'(1);
            r_st_vld    <= '0;
            r_st_rvld   <= 1'b0;
            for (int i = 0; i < thdq_pkg::MAX_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_mode[i] <= thdq_pkg::MODE_RUNNING;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_qc <= i_cfg_queue_count;
            end
            // Hold the result until its transfer, then drop or replace it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (st_re) begin
                r_st_rvld <= r_st_vld[st_raddr];
            end
            if (st_we) begin
                r_st_vld[r_q] <= 1'b1;
            end
            if (head_inc) begin
                r_head[r_qs] <= r_head[r_qs] + 1'b1;
            end
            if (tail_inc) begin
                r_tail[r_q] <= r_tail[r_q] + 1'b1;
            end
            if (mode_we) begin
                r_mode[r_qs] <= mode_val;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_op     <= thdq_pkg::t_req'(i_req_type);
            r_sector <= i_sector;
            r_dir    <= i_direction;
            r_qs     <= i_queue_sel;
            r_tag    <= i_tag_in;
            r_failed <= i_failed;
        end else begin
            r_tag <= n_tag;
        end
        r_res <= n_res;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    thdq_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (r_sector),
        .i_divisor (qc),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    thdq_tag_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pool_cmd),
        .o_stat  (pool_stat)
    );

    // Dispatch rings of all queues
    thdq_ram #(
        .DEPTH (thdq_pkg::RING_DEPTH),
        .WIDTH (thdq_pkg::TAG_W)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr ({r_q, r_tail[r_q]}),
        .i_wdata (pool_stat.found_tag),
        .i_re    (ring_re),
        .i_raddr ({r_qs, r_head[r_qs]}),
        .o_rdata (ring_rdata)
    );

    // Statistics, one row of four counters per queue
    thdq_ram #(
        .DEPTH (thdq_pkg::MAX_QUEUES),
        .WIDTH (thdq_pkg::ROW_W)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_q),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_in_ready        = in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_tag_out         = r_out.tag_out;
    assign o_queue_out       = r_out.queue_out;
    assign o_direction_out   = r_out.dir_out;
    assign o_drained         = r_out.drained;
    assign o_submitted_count = r_out.sub;
    assign o_completed_count = r_out.comp;
    assign o_error_count     = r_out.err;
    assign o_pending_count   = r_out.pend;

    `THDQ_ASSERT(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "second command taken while busy")
    `THDQ_ASSERT(a_alloc_has_free, pool_cmd.alloc |-> (pool_stat.found_ok && !pool_stat.none_free), "tag granted from an empty pool")
    `THDQ_ASSERT(a_drain_empty, (r_state == thdq_pkg::S_DR_END) |-> (r_head[r_qs] == r_tail[r_qs]), "drain finished with tags left in the ring")
    `THDQ_ASSERT_ALWAYS(a_no_load_over_result, (out_load && r_out_valid) |-> i_out_ready, "result overwritten before transfer")

endmodule

// ----- bench/tagged_hw_queue_dispatcher_unit_chk.sv -----
// Checker: predicts dispatcher results from observed transfers and compares them.
module tagged_hw_queue_dispatcher_unit_chk
    import thdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [QC_W-1:0]     i_cfg_queue_count,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [3:0]          i_req_type,
    input  logic [SECTOR_W-1:0] i_sector,
    input  logic                i_direction,
    input  logic [QUEUE_W-1:0]  i_queue_sel,
    input  logic [TAG_W-1:0]    i_tag_in,
    input  logic                i_failed,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2:0]          i_status,
    input  logic [TAG_W-1:0]    i_tag_out,
    input  logic [QUEUE_W-1:0]  i_queue_out,
    input  logic                i_direction_out,
    input  logic [TAG_W-1:0]    i_drained,
    input  logic [CNT_W-1:0]    i_submitted_count,
    input  logic [CNT_W-1:0]    i_completed_count,
    input  logic [CNT_W-1:0]    i_error_count,
    input  logic [CNT_W-1:0]    i_pending_count,
    output int                  o_fail_count,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the dispatcher state
    logic [QC_W-1:0]    queue_count;
    bit                 tag_is_free [TAG_COUNT];
    int unsigned        free_total;
    logic [OWNER_W-1:0] tag_owner [TAG_COUNT];
    bit                 tag_dir [TAG_COUNT];
    logic [TAG_W-1:0]   ring [MAX_QUEUES][TAG_COUNT];
    logic [TAG_W-1:0]   ring_head [MAX_QUEUES];
    logic [TAG_W-1:0]   ring_tail [MAX_QUEUES];
    t_mode              queue_mode [MAX_QUEUES];
    logic [CNT_W-1:0]   n_sub [MAX_QUEUES];
    logic [CNT_W-1:0]   n_comp [MAX_QUEUES];
    logic [CNT_W-1:0]   n_err [MAX_QUEUES];
    logic [CNT_W-1:0]   n_pend [MAX_QUEUES];

    t_result pending_results [$];
    int      fails;
    int      n_outstanding;

    assign o_fail_count  = fails;
    assign o_outstanding = n_outstanding;

    function automatic int unsigned queues_in_use();
        if (queue_count == 0) return 1;
        if (queue_count > MAX_QUEUES) return MAX_QUEUES;
        return 32'(queue_count);
    endfunction

    function automatic void retire_tag(int unsigned t, bit err);
        int unsigned o;
        o = tag_owner[t];
        if (o < queues_in_use()) begin
            n_comp[o]++;
            if (err) n_err[o]++;
            if (n_pend[o] != 0) n_pend[o]--;
        end
        tag_owner[t] = OWNER_NONE;
    endfunction

    function automatic void return_tag(int unsigned t);
        tag_owner[t] = OWNER_NONE;
        if (!tag_is_free[t]) begin
            tag_is_free[t] = 1'b1;
            free_total++;
        end
    endfunction

    // Work out the one result caused by a command
    function automatic t_result dispatch_result(logic [3:0] req, logic [SECTOR_W-1:0] sector,
                                                logic dir, logic [QUEUE_W-1:0] qs,
                                                logic [TAG_W-1:0] tg, logic failed);
        t_result     r;
        int unsigned nq;
        int unsigned t;
        int unsigned q;
        int unsigned n;
        r = '0;
        r.status = ST_OK;
        nq = queues_in_use();
        if (req == REQ_SUBMIT) begin
            if (free_total == 0) begin
                r.status = ST_NO_TAG;
                return r;
            end
            t = 0;
            while (t < TAG_COUNT && !tag_is_free[t]) t++;
            q = int'(sector % SECTOR_W'(nq));
            r.queue_out = QUEUE_W'(q);
            if (queue_mode[q] != MODE_RUNNING) begin
                r.status = ST_NOT_RUNNING;
            end else if (TAG_W'(ring_tail[q] + 1) == ring_head[q]) begin
                r.status = ST_FULL;
            end else begin
                tag_is_free[t] = 1'b0;
                free_total--;
                tag_owner[t] = OWNER_W'(q);
                tag_dir[t] = dir;
                ring[q][ring_tail[q]] = TAG_W'(t);
                ring_tail[q]++;
                n_sub[q]++;
                n_pend[q]++;
                r.tag_out = TAG_W'(t);
            end
            return r;
        end
        if (req == REQ_COMPLETE) begin
            retire_tag(tg, failed);
            return r;
        end
        if (req == REQ_RELEASE) begin
            return_tag(tg);
            return r;
        end
        if (req > REQ_STATS) return r;
        if (qs >= nq) begin
            r.status = ST_BAD_QUEUE;
            return r;
        end
        case (req)
            REQ_FETCH: begin
                if (queue_mode[qs] != MODE_RUNNING) begin
                    r.status = ST_NOT_RUNNING;
                end else if (ring_head[qs] == ring_tail[qs]) begin
                    r.status = ST_EMPTY;
                end else begin
                    t = ring[qs][ring_head[qs]];
                    ring_head[qs]++;
                    r.tag_out = TAG_W'(t);
                    r.dir_out = tag_dir[t];
                end
            end
            REQ_START: begin
                if (queue_mode[qs] == MODE_OFFLINE) r.status = ST_NOT_RUNNING;
                else queue_mode[qs] = MODE_RUNNING;
            end
            REQ_STOP: begin
                if (queue_mode[qs] == MODE_RUNNING) queue_mode[qs] = MODE_STOPPED;
            end
            REQ_DRAIN: begin
                n = 0;
                while (ring_head[qs] != ring_tail[qs]) begin
                    t = ring[qs][ring_head[qs]];
                    ring_head[qs]++;
                    retire_tag(t, 1'b1);
                    return_tag(t);
                    n++;
                end
                n_pend[qs] = '0;
                queue_mode[qs] = MODE_OFFLINE;
                r.drained = TAG_W'(n);
            end
            REQ_EXIT: begin
                if (n_pend[qs] != 0) r.status = ST_BUSY;
                else queue_mode[qs] = MODE_OFFLINE;
            end
            default: begin
                r.sub  = n_sub[qs];
                r.comp = n_comp[qs];
                r.err  = n_err[qs];
                r.pend = n_pend[qs];
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $realtime, name,
                     exp_v, act_v);
            fails++;
        end
    endtask

    // Track configuration, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            queue_count = 1;
            free_total = TAG_COUNT;
            for (int i = 0; i < TAG_COUNT; i++) begin
                tag_is_free[i] = 1'b1;
                tag_owner[i] = OWNER_NONE;
                tag_dir[i] = 1'b0;
            end
            for (int q = 0; q < MAX_QUEUES; q++) begin
                ring_head[q] = '0;
                ring_tail[q] = '0;
                queue_mode[q] = MODE_RUNNING;
                n_sub[q] = '0;
                n_comp[q] = '0;
                n_err[q] = '0;
                n_pend[q] = '0;
            end
            pending_results.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) queue_count = i_cfg_queue_count;
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result transfer with nothing expected, actual status %0h",
                             $realtime, i_status);
                    fails++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("status", CNT_W'(exp_r.status), CNT_W'(i_status));
                    check_field("tag_out", CNT_W'(exp_r.tag_out), CNT_W'(i_tag_out));
                    check_field("queue_out", CNT_W'(exp_r.queue_out), CNT_W'(i_queue_out));
                    check_field("direction_out", CNT_W'(exp_r.dir_out),
                                CNT_W'(i_direction_out));
                    check_field("drained", CNT_W'(exp_r.drained), CNT_W'(i_drained));
                    check_field("submitted_count", exp_r.sub, i_submitted_count);
                    check_field("completed_count", exp_r.comp, i_completed_count);
                    check_field("error_count", exp_r.err, i_error_count);
                    check_field("pending_count", exp_r.pend, i_pending_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(dispatch_result(i_req_type, i_sector, i_direction,
                                                          i_queue_sel, i_tag_in, i_failed));
            end
        end
        n_outstanding = pending_results.size();
    end

endmodule

// ----- bench/tagged_hw_queue_dispatcher_unit_tb.sv -----
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module tagged_hw_queue_dispatcher_unit_tb;
    import thdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 8000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [QC_W-1:0]     i_cfg_queue_count;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [3:0]          i_req_type;
    logic [SECTOR_W-1:0] i_sector;
    logic                i_direction;
    logic [QUEUE_W-1:0]  i_queue_sel;
    logic [TAG_W-1:0]    i_tag_in;
    logic                i_failed;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [2:0]          o_status;
    logic [TAG_W-1:0]    o_tag_out;
    logic [QUEUE_W-1:0]  o_queue_out;
    logic                o_direction_out;
    logic [TAG_W-1:0]    o_drained;
    logic [CNT_W-1:0]    o_submitted_count;
    logic [CNT_W-1:0]    o_completed_count;
    logic [CNT_W-1:0]    o_error_count;
    logic [CNT_W-1:0]    o_pending_count;

    int fail_count;
    int outstanding;
    int quiet_cycles;
    bit no_idle;
    bit long_hold;
    int unsigned live_queues;

    tagged_hw_queue_dispatcher_unit DUT (.*);

    tagged_hw_queue_dispatcher_unit_chk u_chk (
        .i_in_ready    (o_in_ready),
        .i_out_valid   (o_out_valid),
        .i_status      (o_status),
        .i_tag_out     (o_tag_out),
        .i_queue_out   (o_queue_out),
        .i_direction_out (o_direction_out),
        .i_drained     (o_drained),
        .i_submitted_count (o_submitted_count),
        .i_completed_count (o_completed_count),
        .i_error_count (o_error_count),
        .i_pending_count (o_pending_count),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL tagged_hw_queue_dispatcher_unit");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one command and hold it until the transfer
    task automatic send_cmd(t_req rq, logic [SECTOR_W-1:0] sec, logic dir,
                            logic [QUEUE_W-1:0] qs, logic [TAG_W-1:0] tg, logic fl);
        send_raw(rq, sec, dir, qs, tg, fl);
    endtask

    task automatic send_raw(logic [3:0] rq, logic [SECTOR_W-1:0] sec, logic dir,
                            logic [QUEUE_W-1:0] qs, logic [TAG_W-1:0] tg, logic fl);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= rq;
        i_sector    <= sec;
        i_direction <= dir;
        i_queue_sel <= qs;
        i_tag_in    <= tg;
        i_failed    <= fl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Pause the sender until every result is back, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_queue_count(logic [QC_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_queue_count <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (v == 0) live_queues = 1;
        else if (v > MAX_QUEUES) live_queues = MAX_QUEUES;
        else live_queues = v;
    endtask

    // One random command; fill mode grows a single ring toward full and the pool toward empty
    task automatic send_random(bit fill);
        int unsigned pick;
        logic [3:0] rq;
        logic [SECTOR_W-1:0] sec;
        logic [QUEUE_W-1:0] qs;
        logic [TAG_W-1:0] tg;
        pick = $urandom_range(0, 99);
        if (fill) begin
            rq = pick < 55 ? REQ_SUBMIT : pick < 93 ? REQ_RELEASE :
                 pick < 97 ? REQ_FETCH : REQ_STATS;
        end else begin
            rq = pick < 32 ? REQ_SUBMIT : pick < 52 ? REQ_FETCH :
                 pick < 68 ? REQ_COMPLETE : pick < 82 ? REQ_RELEASE :
                 pick < 86 ? REQ_START : pick < 89 ? REQ_STOP :
                 pick < 90 ? REQ_DRAIN : pick < 91 ? REQ_EXIT :
                 pick < 97 ? REQ_STATS : 4'($urandom_range(9, 15));
        end
        sec = $urandom_range(0, 3) == 0 ? SECTOR_W'($urandom_range(0, 40))
                                        : {$urandom, $urandom};
        qs = $urandom_range(0, 99) < 88 ? QUEUE_W'($urandom_range(0, live_queues - 1))
                                        : QUEUE_W'($urandom);
        tg = $urandom_range(0, 9) < 7 ? TAG_W'($urandom_range(0, 63)) : TAG_W'($urandom);
        send_raw(rq, sec, 1'($urandom), qs, tg, 1'($urandom));
    endtask

    initial begin
        logic [QC_W-1:0] phase_qc [6];
        int              phase_len [6];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_queue_count = '0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_sector = '0;
        i_direction = 1'b0;
        i_queue_sel = '0;
        i_tag_in = '0;
        i_failed = 1'b0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        live_queues = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every command and the corner cases, on high queues only
        set_queue_count(QC_W'(MAX_QUEUES));
        send_cmd(REQ_SUBMIT, '1, 1'b0, '0, '0, 1'b0);
        send_cmd(REQ_SUBMIT, 64'd13, 1'b1, '0, '0, 1'b0);
        send_cmd(REQ_FETCH, '0, 1'b0, 4'd13, '0, 1'b0);
        send_cmd(REQ_FETCH, '0, 1'b0, 4'd13, '0, 1'b0);
        send_cmd(REQ_COMPLETE, '0, 1'b0, '0, 8'd1, 1'b1);
        send_cmd(REQ_COMPLETE, '0, 1'b0, '0, 8'd255, 1'b0);
        send_cmd(REQ_STATS, '0, 1'b0, 4'd13, '0, 1'b0);
        send_cmd(REQ_RELEASE, '0, 1'b0, '0, 8'd1, 1'b0);
        send_cmd(REQ_RELEASE, '0, 1'b0, '0, 8'd1, 1'b0);
        send_cmd(REQ_STOP, '0, 1'b0, 4'd14, '0, 1'b0);
        send_cmd(REQ_STOP, '0, 1'b0, 4'd14, '0, 1'b0);
        send_cmd(REQ_SUBMIT, 64'd14, 1'b1, '0, '0, 1'b0);
        send_cmd(REQ_FETCH, '0, 1'b0, 4'd14, '0, 1'b0);
        send_cmd(REQ_START, '0, 1'b0, 4'd14, '0, 1'b0);
        send_cmd(REQ_SUBMIT, 64'd30, 1'b1, '0, '0, 1'b0);
        send_cmd(REQ_RELEASE, '0, 1'b0, '0, 8'd1, 1'b0);
        send_cmd(REQ_FETCH, '0, 1'b0, 4'd14, '0, 1'b0);
        send_cmd(REQ_EXIT, '0, 1'b0, 4'd15, '0, 1'b0);
        send_cmd(REQ_DRAIN, '0, 1'b0, 4'd15, '0, 1'b0);
        send_cmd(REQ_STATS, '0, 1'b0, 4'd15, '0, 1'b0);
        send_cmd(REQ_START, '0, 1'b0, 4'd15, '0, 1'b0);
        send_cmd(REQ_EXIT, '0, 1'b0, 4'd12, '0, 1'b0);
        send_raw(4'd9, '1, 1'b1, '1, '1, 1'b1);
        send_raw(4'd15, '0, 1'b0, '0, '0, 1'b0);
        drain_results();

        // Random phases over several queue counts, extremes included
        phase_qc = '{QC_W'(1), QC_W'(MAX_QUEUES), QC_W'(0), QC_W'(31),
                     QC_W'($urandom_range(2, 11)), QC_W'($urandom_range(3, 8))};
        phase_len = '{340, 220, 160, 160, 160, 86};
        foreach (phase_qc[p]) begin
            set_queue_count(phase_qc[p]);
            if (p == 1) long_hold = 1'b1;
            if (p == 5) no_idle = 1'b1;
            for (int n = 0; n < phase_len[p]; n++) send_random(p == 0);
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS tagged_hw_queue_dispatcher_unit");
        end else begin
            $display("FAIL tagged_hw_queue_dispatcher_unit");
        end
        $finish;
    end

endmodule

// ----- tagged_hw_queue_dispatcher_unit.f -----
+incdir+rtl
rtl/thdq_pkg.sv
rtl/thdq_ram.sv
rtl/thdq_mod.sv
rtl/thdq_tag_pool.sv
rtl/tagged_hw_queue_dispatcher_unit.sv
bench/tagged_hw_queue_dispatcher_unit_chk.sv
bench/tagged_hw_queue_dispatcher_unit_tb.sv
